// ----- rtl/salwcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salwcc_pkg
// shared types and codes of the set associative write-back cache controller
// ----------------------------------------------------------------------------
package salwcc_pkg;

   // access codes on the operation field
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // per-line coherence state
   typedef enum logic [1:0] {
      LINE_INVALID = 2'd0,
      LINE_CLEAN   = 2'd1,
      LINE_DIRTY   = 2'd2
   } line_state_type;

   // lookup outcome flags handed from the lookup logic to the result stage
   typedef struct packed {
      logic hit;
      logic fill_needed;
      logic writeback_needed;
      logic line_dirty;
   } lookup_flags_type;

endpackage

// ----- rtl/salwcc_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salwcc_req_if
// access request channel: valid/ready plus operation and physical address
// ----------------------------------------------------------------------------
interface salwcc_req_if #(
   parameter int ADDR_BITS = 52
);
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [ADDR_BITS-1:0] phys_address;

   modport source (output valid, output operation, output phys_address, input ready);
   modport sink   (input valid, input operation, input phys_address, output ready);
endinterface

// ----- rtl/salwcc_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salwcc_rsp_if
// lookup result channel: valid/ready plus hit, way and writeback info
// ----------------------------------------------------------------------------
interface salwcc_rsp_if #(
   parameter int ADDR_BITS = 52,
   parameter int WAY_BITS  = 3
);
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [WAY_BITS-1:0]  way;
   logic                 fill_needed;
   logic                 writeback_needed;
   logic [ADDR_BITS-1:0] writeback_address;
   logic                 line_dirty;

   modport source (
      output valid, output hit, output way, output fill_needed,
      output writeback_needed, output writeback_address, output line_dirty,
      input ready
   );
   modport sink (
      input valid, input hit, input way, input fill_needed,
      input writeback_needed, input writeback_address, input line_dirty,
      output ready
   );
endinterface

// ----- rtl/salwcc_set_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salwcc_set_store
// per-set tag, state and rank rows with registered read and write bypass
// ----------------------------------------------------------------------------
module salwcc_set_store #(
   parameter int WAYS      = 8,
   parameter int SET_BITS  = 6,
   parameter int TAG_BITS  = 40,
   parameter int RANK_BITS = 3
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   rd_en,
   input  logic [SET_BITS-1:0]                    rd_set,
   input  logic                                   wr_en,
   input  logic [SET_BITS-1:0]                    wr_set,
   input  logic [WAYS-1:0][TAG_BITS-1:0]          wr_tags,
   input  salwcc_pkg::line_state_type [WAYS-1:0]  wr_states,
   input  logic [WAYS-1:0][RANK_BITS-1:0]         wr_ranks,
   output logic [WAYS-1:0][TAG_BITS-1:0]          rd_tags,
   output salwcc_pkg::line_state_type [WAYS-1:0]  rd_states,
   output logic [WAYS-1:0][RANK_BITS-1:0]         rd_ranks
);
   import salwcc_pkg::*;

   localparam int NSETS = 1 << SET_BITS;

   logic [WAYS-1:0][TAG_BITS-1:0]  tag_mem   [NSETS];
   line_state_type [WAYS-1:0]      state_mem [NSETS];
   logic [WAYS-1:0][RANK_BITS-1:0] rank_mem  [NSETS];

   logic [NSETS-1:0]               row_vld_ff;
   logic                           rd_row_vld_ff;
   logic [SET_BITS-1:0]            rd_set_ff;
   logic [WAYS-1:0][TAG_BITS-1:0]  rd_tags_ff;
   line_state_type [WAYS-1:0]      rd_states_ff;
   logic [WAYS-1:0][RANK_BITS-1:0] rd_ranks_ff;

   // copy of the most recent row write
   logic                           last_vld_ff;
   logic [SET_BITS-1:0]            last_set_ff;
   logic [WAYS-1:0][TAG_BITS-1:0]  last_tags_ff;
   line_state_type [WAYS-1:0]      last_states_ff;
   logic [WAYS-1:0][RANK_BITS-1:0] last_ranks_ff;

   // memories and read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[wr_set]   <= wr_tags;
         state_mem[wr_set] <= wr_states;
         rank_mem[wr_set]  <= wr_ranks;
         last_set_ff       <= wr_set;
         last_tags_ff      <= wr_tags;
         last_states_ff    <= wr_states;
         last_ranks_ff     <= wr_ranks;
      end
      if (rd_en) begin
         rd_set_ff    <= rd_set;
         rd_tags_ff   <= tag_mem[rd_set];
         rd_states_ff <= state_mem[rd_set];
         rd_ranks_ff  <= rank_mem[rd_set];
      end
   end

   // rows never written read as the reset row
   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff    <= '0;
         rd_row_vld_ff <= 1'b0;
         last_vld_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            row_vld_ff[wr_set] <= 1'b1;
            last_vld_ff        <= 1'b1;
         end
         if (rd_en) begin
            rd_row_vld_ff <= row_vld_ff[rd_set];
         end
      end
   end

   // latest write to the same set wins over the memory copy
   always_comb begin
      if (last_vld_ff && (last_set_ff == rd_set_ff)) begin
         rd_tags   = last_tags_ff;
         rd_states = last_states_ff;
         rd_ranks  = last_ranks_ff;
      end else if (rd_row_vld_ff) begin
         rd_tags   = rd_tags_ff;
         rd_states = rd_states_ff;
         rd_ranks  = rd_ranks_ff;
      end else begin
         rd_tags = rd_tags_ff;
         for (int w = 0; w < WAYS; w++) begin
            rd_states[w] = LINE_INVALID;
            rd_ranks[w]  = RANK_BITS'(w);
         end
      end
   end

endmodule

// ----- rtl/salwcc_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salwcc_lookup
// tag compare, way selection and next row contents for one access
// ----------------------------------------------------------------------------
module salwcc_lookup #(
   parameter int WAYS        = 8,
   parameter int SET_BITS    = 6,
   parameter int OFFSET_BITS = 6,
   parameter int ADDR_BITS   = 52,
   parameter int TAG_BITS    = ADDR_BITS - SET_BITS - OFFSET_BITS,
   parameter int RANK_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  logic                                   is_write,
   input  logic [SET_BITS-1:0]                    req_set,
   input  logic [TAG_BITS-1:0]                    req_tag,
   input  logic [WAYS-1:0][TAG_BITS-1:0]          tags,
   input  salwcc_pkg::line_state_type [WAYS-1:0]  states,
   input  logic [WAYS-1:0][RANK_BITS-1:0]         ranks,
   output logic [RANK_BITS-1:0]                   sel_way,
   output salwcc_pkg::lookup_flags_type           flags,
   output logic [ADDR_BITS-1:0]                   wb_address,
   output logic [WAYS-1:0][TAG_BITS-1:0]          new_tags,
   output salwcc_pkg::line_state_type [WAYS-1:0]  new_states,
   output logic [WAYS-1:0][RANK_BITS-1:0]         new_ranks
);
   import salwcc_pkg::*;

   logic                 hit;
   logic                 have_inv;
   logic [RANK_BITS-1:0] hit_way;
   logic [RANK_BITS-1:0] inv_way;
   logic [RANK_BITS-1:0] victim;
   logic [RANK_BITS-1:0] old_rank;
   logic                 wb;

   // parallel compare; lowest hit, highest invalid, oldest rank
   always_comb begin
      hit      = 1'b0;
      have_inv = 1'b0;
      hit_way  = '0;
      inv_way  = '0;
      victim   = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (states[w] != LINE_INVALID) begin
            if (!hit && (tags[w] == req_tag)) begin
               hit     = 1'b1;
               hit_way = RANK_BITS'(w);
            end
         end else begin
            have_inv = 1'b1;
            inv_way  = RANK_BITS'(w);
         end
         if (ranks[w] == RANK_BITS'(WAYS - 1)) begin
            victim = RANK_BITS'(w);
         end
      end
   end

   always_comb begin
      if (hit) begin
         sel_way = hit_way;
      end else if (have_inv) begin
         sel_way = inv_way;
      end else begin
         sel_way = victim;
      end
   end

   assign wb = !hit && !have_inv && (states[victim] == LINE_DIRTY);
   assign wb_address = wb ? {tags[victim], req_set, OFFSET_BITS'(0)} : '0;

   // row update
   always_comb begin
      new_tags   = tags;
      new_states = states;
      if (hit) begin
         if (is_write) begin
            new_states[sel_way] = LINE_DIRTY;
         end
      end else begin
         new_tags[sel_way]   = req_tag;
         new_states[sel_way] = is_write ? LINE_DIRTY : LINE_CLEAN;
      end
   end

   // selected way goes to rank 0, younger ways age by one
   assign old_rank = ranks[sel_way];

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         if (RANK_BITS'(w) == sel_way) begin
            new_ranks[w] = '0;
         end else if (ranks[w] < old_rank) begin
            new_ranks[w] = ranks[w] + RANK_BITS'(1);
         end else begin
            new_ranks[w] = ranks[w];
         end
      end
   end

   assign flags.hit              = hit;
   assign flags.fill_needed      = !hit;
   assign flags.writeback_needed = wb;
   assign flags.line_dirty       = (new_states[sel_way] == LINE_DIRTY);

endmodule

// ----- rtl/set_assoc_lru_writeback_cache_ctrl_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_ctrl_unit
// tag, state and lru controller of a set associative write-back cache
// ----------------------------------------------------------------------------
// Takes one read or write access per clock while results drain, limited by
// the single read and write port of the set memories, and answers with hit,
// the way that now holds the line, whether a fill is needed and, when a
// dirty line is evicted, the victim's own line address. The set row (tags,
// line states, recency ranks) is read from memory on the accepting edge; the
// compare, way choice and row update then run in the lookup stage into the
// result register. A bypass of the last written row keeps back-to-back
// accesses to one set exact. A per-set valid bit makes untouched sets read as
// all invalid with rank equal to way, so no clearing pass follows reset. A
// stalled result holds the lookup stage, and the request side keeps accepting
// while the lookup stage can move on.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache_ctrl_unit #(
   parameter int WAYS        = 8,
   parameter int SET_BITS    = 6,
   parameter int OFFSET_BITS = 6,
   parameter int ADDR_BITS   = 52
) (
   input  logic  clock,
   input  logic  reset,
   salwcc_req_if.sink   req_ch,
   salwcc_rsp_if.source rsp_ch
);
   import salwcc_pkg::*;

   localparam int TAG_BITS  = ADDR_BITS - SET_BITS - OFFSET_BITS;
   localparam int RANK_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;

   // handshake
   logic req_accept;
   logic s1_move;

   // lookup stage
   logic                s1_vld_ff;
   logic                s1_write_ff;
   logic [SET_BITS-1:0] s1_set_ff;
   logic [TAG_BITS-1:0] s1_tag_ff;

   // set row as seen by the lookup stage
   logic [WAYS-1:0][TAG_BITS-1:0]  row_tags;
   line_state_type [WAYS-1:0]      row_states;
   logic [WAYS-1:0][RANK_BITS-1:0] row_ranks;

   // lookup outcome
   logic [RANK_BITS-1:0]           sel_way;
   lookup_flags_type               flags;
   logic [ADDR_BITS-1:0]           wb_address;
   logic [WAYS-1:0][TAG_BITS-1:0]  new_tags;
   line_state_type [WAYS-1:0]      new_states;
   logic [WAYS-1:0][RANK_BITS-1:0] new_ranks;

   // result register
   logic                 rsp_vld_ff;
   logic [RANK_BITS-1:0] rsp_way_ff;
   lookup_flags_type     rsp_flags_ff;
   logic [ADDR_BITS-1:0] rsp_wb_addr_ff;

   // lookup stage moves whenever the result register is free or being drained
   assign s1_move    = s1_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_vld_ff || s1_move;
   assign req_accept = req_ch.valid && req_ch.ready;

   // stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_move) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // stage payload, split the address on entry
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_write_ff <= (req_ch.operation == OP_WRITE);
         s1_set_ff   <= req_ch.phys_address[OFFSET_BITS +: SET_BITS];
         s1_tag_ff   <= req_ch.phys_address[ADDR_BITS-1 -: TAG_BITS];
      end
      if (s1_move) begin
         rsp_way_ff     <= sel_way;
         rsp_flags_ff   <= flags;
         rsp_wb_addr_ff <= wb_address;
      end
   end

   // set rows: read on accept, written back when the lookup retires
   salwcc_set_store #(
      .WAYS      (WAYS),
      .SET_BITS  (SET_BITS),
      .TAG_BITS  (TAG_BITS),
      .RANK_BITS (RANK_BITS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept),
      .rd_set    (req_ch.phys_address[OFFSET_BITS +: SET_BITS]),
      .wr_en     (s1_move),
      .wr_set    (s1_set_ff),
      .wr_tags   (new_tags),
      .wr_states (new_states),
      .wr_ranks  (new_ranks),
      .rd_tags   (row_tags),
      .rd_states (row_states),
      .rd_ranks  (row_ranks)
   );

   // compare, victim choice and rank update
   salwcc_lookup #(
      .WAYS        (WAYS),
      .SET_BITS    (SET_BITS),
      .OFFSET_BITS (OFFSET_BITS),
      .ADDR_BITS   (ADDR_BITS),
      .TAG_BITS    (TAG_BITS),
      .RANK_BITS   (RANK_BITS)
   ) u_lookup (
      .is_write   (s1_write_ff),
      .req_set    (s1_set_ff),
      .req_tag    (s1_tag_ff),
      .tags       (row_tags),
      .states     (row_states),
      .ranks      (row_ranks),
      .sel_way    (sel_way),
      .flags      (flags),
      .wb_address (wb_address),
      .new_tags   (new_tags),
      .new_states (new_states),
      .new_ranks  (new_ranks)
   );

   // result word
   assign rsp_ch.valid             = rsp_vld_ff;
   assign rsp_ch.hit               = rsp_flags_ff.hit;
   assign rsp_ch.way               = rsp_way_ff;
   assign rsp_ch.fill_needed       = rsp_flags_ff.fill_needed;
   assign rsp_ch.writeback_needed  = rsp_flags_ff.writeback_needed;
   assign rsp_ch.writeback_address = rsp_wb_addr_ff;
   assign rsp_ch.line_dirty        = rsp_flags_ff.line_dirty;

endmodule

// ----- tb/set_assoc_lru_writeback_cache_ctrl_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_ctrl_unit_tb
// self-checking bench for the set associative write-back cache controller
// ----------------------------------------------------------------------------
// Access words go in through a queue-fed driver. As each access is accepted,
// a local copy of the tag, line state and recency rank arrays works out the
// result word that the lookup must give. A monitor checks the result words
// in order against those predictions.
// A short directed opening fills one set, hits it and forces clean and dirty
// evictions. Random accesses then hammer a few hot sets with a small tag
// pool, so hits, fills and dirty evictions all come often. Three phases
// shift the back pressure between the two sides.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache_ctrl_unit_tb;
   import salwcc_pkg::*;

   localparam int WAYS        = 8;
   localparam int SET_BITS    = 6;
   localparam int OFFSET_BITS = 6;
   localparam int ADDR_BITS   = 52;
   localparam int WAY_BITS    = 3;
   localparam int SETS        = 1 << SET_BITS;
   localparam int TAG_BITS    = ADDR_BITS - SET_BITS - OFFSET_BITS;

   localparam int RANDOM_PER_PHASE = 445;   // three phases plus the directed part
   localparam int TAG_POOL_SIZE    = 12;    // more tags than ways, so hot sets thrash
   localparam int HOT_SETS         = 4;
   localparam int DRAIN_CYCLES     = 8;     // lookup stage and result register plus margin
   localparam int WATCHDOG_LIMIT   = 2000;  // cycles with no word moving on either side
   localparam int REPORT_LIMIT     = 10;

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [TAG_BITS-1:0]  tag_type;

   typedef struct packed {
      logic     operation;
      addr_type phys_address;
   } access_word_type;

   typedef struct packed {
      logic                hit;
      logic [WAY_BITS-1:0] way;
      logic                fill_needed;
      logic                writeback_needed;
      addr_type            writeback_address;
      logic                line_dirty;
   } lookup_word_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   salwcc_req_if #(.ADDR_BITS(ADDR_BITS)) req_ch ();
   salwcc_rsp_if #(.ADDR_BITS(ADDR_BITS), .WAY_BITS(WAY_BITS)) rsp_ch ();

   set_assoc_lru_writeback_cache_ctrl_unit #(
      .WAYS        (WAYS),
      .SET_BITS    (SET_BITS),
      .OFFSET_BITS (OFFSET_BITS),
      .ADDR_BITS   (ADDR_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // --------------------------------------------------------------------------
   // cache directory mirror: tags, line states and recency ranks per set
   // rank 0 is most recent, WAYS-1 is the next victim
   // --------------------------------------------------------------------------
   tag_type             line_tag   [SETS][WAYS];
   line_state_type      line_state [SETS][WAYS];
   logic [WAY_BITS-1:0] lru_rank   [SETS][WAYS];

   // stimulus pools and queues
   tag_type             tag_pool [TAG_POOL_SIZE];
   logic [SET_BITS-1:0] hot_set  [HOT_SETS];
   access_word_type     pending_accesses [$];
   lookup_word_type     expected_lookups [$];

   // back pressure per phase, percent of cycles
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // run statistics
   int accesses_sent   = 0;
   int writes_sent     = 0;
   int hits_predicted  = 0;
   int dirty_evictions = 0;
   int lookups_checked = 0;
   int mismatches      = 0;
   int idle_cycles     = 0;

   // look up one access in the mirror, update it and return the result word
   function automatic lookup_word_type lookup_and_update(access_word_type acc);
      lookup_word_type     res;
      logic [SET_BITS-1:0] set_idx;
      tag_type             tag;
      logic [WAY_BITS-1:0] sel;
      logic [WAY_BITS-1:0] free_way;
      logic [WAY_BITS-1:0] victim;
      logic [WAY_BITS-1:0] old_rank;
      logic                found;
      logic                have_free;
      int                  w;

      set_idx   = acc.phys_address[OFFSET_BITS +: SET_BITS];
      tag       = acc.phys_address[ADDR_BITS-1 -: TAG_BITS];
      res       = '0;
      found     = 1'b0;
      have_free = 1'b0;
      sel       = '0;
      free_way  = '0;
      victim    = '0;

      for (w = 0; w < WAYS; w++) begin
         if (line_state[set_idx][w] != LINE_INVALID) begin
            // first matching valid way wins
            if (!found && line_tag[set_idx][w] == tag) begin
               found = 1'b1;
               sel   = WAY_BITS'(w);
            end
         end else begin
            // keeps the highest-numbered free way
            have_free = 1'b1;
            free_way  = WAY_BITS'(w);
         end
         if (lru_rank[set_idx][w] >= lru_rank[set_idx][victim])
            victim = WAY_BITS'(w);
      end

      if (found) begin
         if (acc.operation == OP_WRITE)
            line_state[set_idx][sel] = LINE_DIRTY;
      end else begin
         sel = have_free ? free_way : victim;
         // writeback address comes from the victim's own tag, not the request
         if (!have_free && line_state[set_idx][sel] == LINE_DIRTY) begin
            res.writeback_needed  = 1'b1;
            res.writeback_address = {line_tag[set_idx][sel], set_idx, {OFFSET_BITS{1'b0}}};
         end
         line_tag[set_idx][sel]   = tag;
         line_state[set_idx][sel] = (acc.operation == OP_WRITE) ? LINE_DIRTY : LINE_CLEAN;
      end

      // selected way becomes most recent, the ones that were newer age by one
      old_rank = lru_rank[set_idx][sel];
      for (w = 0; w < WAYS; w++)
         if (lru_rank[set_idx][w] < old_rank)
            lru_rank[set_idx][w] = lru_rank[set_idx][w] + 1'b1;
      lru_rank[set_idx][sel] = '0;

      res.hit         = found;
      res.way         = sel;
      res.fill_needed = !found;
      res.line_dirty  = (line_state[set_idx][sel] == LINE_DIRTY);
      return res;
   endfunction

   // mostly pooled tags in hot sets, some pooled tags anywhere, some noise
   function automatic access_word_type random_access();
      access_word_type acc;
      int              pick;

      pick             = $urandom_range(0, 99);
      acc.operation    = 1'($urandom_range(0, 1));
      acc.phys_address = addr_type'({$urandom, $urandom});
      if (pick < 90) begin
         acc.phys_address[ADDR_BITS-1 -: TAG_BITS] =
            tag_pool[$urandom_range(0, TAG_POOL_SIZE - 1)];
         if (pick < 70)
            acc.phys_address[OFFSET_BITS +: SET_BITS] = hot_set[$urandom_range(0, HOT_SETS - 1)];
      end
      return acc;
   endfunction

   task automatic queue_access(input logic op, input tag_type tag, input int set_idx,
                               input int offset);
      access_word_type acc;

      acc.operation    = op;
      acc.phys_address = {tag, SET_BITS'(set_idx), OFFSET_BITS'(offset)};
      pending_accesses.push_back(acc);
   endtask

   task automatic wait_pending_empty();
      while (pending_accesses.size() != 0)
         @(posedge clock);
   endtask

   // --------------------------------------------------------------------------
   // driver: presents the next access once the current word is taken
   // prediction happens on the accepting edge, in acceptance order
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : access_driver
      access_word_type cur;
      lookup_word_type predicted;

      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            cur.operation    = req_ch.operation;
            cur.phys_address = req_ch.phys_address;
            predicted        = lookup_and_update(cur);
            expected_lookups.push_back(predicted);
            accesses_sent++;
            if (cur.operation == OP_WRITE)
               writes_sent++;
            if (predicted.hit)
               hits_predicted++;
            if (predicted.writeback_needed)
               dirty_evictions++;
         end
         // hold the word while it waits; otherwise offer the next one or idle
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_accesses.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur                 = pending_accesses.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.operation    <= cur.operation;
               req_ch.phys_address <= cur.phys_address;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // monitor: random ready, every taken result word checked against the oldest
   // prediction
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : lookup_monitor
      lookup_word_type got;
      lookup_word_type want;

      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.hit               = rsp_ch.hit;
            got.way               = rsp_ch.way;
            got.fill_needed       = rsp_ch.fill_needed;
            got.writeback_needed  = rsp_ch.writeback_needed;
            got.writeback_address = rsp_ch.writeback_address;
            got.line_dirty        = rsp_ch.line_dirty;
            if (expected_lookups.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: result word with no access outstanding (hit %b way %0d)",
                           $realtime, got.hit, got.way);
            end else begin
               want = expected_lookups.pop_front();
               lookups_checked++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $write("%0t: lookup %0d mismatch (exp/got) hit %b/%b way %0d/%0d ",
                            $realtime, lookups_checked, want.hit, got.hit, want.way,
                            got.way);
                     $display("fill %b/%b wb %b/%b wb_addr %h/%h dirty %b/%b",
                              want.fill_needed, got.fill_needed, want.writeback_needed,
                              got.writeback_needed, want.writeback_address,
                              got.writeback_address, want.line_dirty, got.line_dirty);
                  end
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // watchdog: too long without any word moving means the block is stuck
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles with no traffic", WATCHDOG_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // --------------------------------------------------------------------------
   // stimulus and end of run
   // --------------------------------------------------------------------------
   initial begin : stimulus
      int set_idx;
      int w;
      int i;

      // directory after reset: all invalid, rank equal to way number
      for (set_idx = 0; set_idx < SETS; set_idx++)
         for (w = 0; w < WAYS; w++) begin
            line_tag[set_idx][w]   = '0;
            line_state[set_idx][w] = LINE_INVALID;
            lru_rank[set_idx][w]   = WAY_BITS'(w);
         end

      for (i = 0; i < TAG_POOL_SIZE; i++)
         tag_pool[i] = tag_type'({$urandom, $urandom});
      // both edge sets are hot, plus two random ones
      hot_set[0] = '0;
      hot_set[1] = '1;
      hot_set[2] = SET_BITS'($urandom_range(1, SETS - 2));
      hot_set[3] = SET_BITS'($urandom_range(1, SETS - 2));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct  = 11;
      recv_stall_pct = 48;

      // zero address miss, then a write hit at the top of the same line
      queue_access(OP_READ, '0, 0, 0);
      queue_access(OP_WRITE, '0, 0, SETS - 1);
      // all-ones address: top set, top tag, miss then write hit
      queue_access(OP_READ, '1, SETS - 1, (1 << OFFSET_BITS) - 1);
      queue_access(OP_WRITE, '1, SETS - 1, (1 << OFFSET_BITS) - 1);
      // fill set 1 from the top way down, mixing clean and dirty lines;
      // the first fill uses the all-ones tag so its writeback address has a full tag
      for (i = 0; i < WAYS; i++)
         queue_access((i % 2 == 0) ? OP_WRITE : OP_READ, (i == 0) ? '1 : tag_type'(i), 1, i);
      // read hit refreshes a line, write hit turns a clean line dirty
      queue_access(OP_READ, tag_type'(1), 1, 0);
      queue_access(OP_WRITE, tag_type'(5), 1, 7);
      // full set: evict dirty all-ones line, then a dirty one, then a clean one
      queue_access(OP_READ, tag_type'(8), 1, 0);
      queue_access(OP_WRITE, tag_type'(9), 1, 0);
      queue_access(OP_READ, tag_type'(10), 1, 0);

      // phase one: light sender gaps, heavy result back pressure
      repeat (RANDOM_PER_PHASE) pending_accesses.push_back(random_access());
      wait_pending_empty();

      // phase two: the other way round
      send_idle_pct  = 48;
      recv_stall_pct = 11;
      repeat (RANDOM_PER_PHASE) pending_accesses.push_back(random_access());
      wait_pending_empty();

      // phase three: both sides at full rate
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (RANDOM_PER_PHASE) pending_accesses.push_back(random_access());
      wait_pending_empty();

      // let the last word get taken, then drain every outstanding lookup
      @(posedge clock);
      while (req_ch.valid || expected_lookups.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d accesses (%0d writes): %0d hits, %0d fills, %0d dirty evictions",
               accesses_sent, writes_sent, hits_predicted, accesses_sent - hits_predicted,
               dirty_evictions);
      $display("checked %0d result words, %0d mismatches, %0d still outstanding",
               lookups_checked, mismatches, expected_lookups.size());
      if (mismatches == 0 && expected_lookups.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- set_assoc_lru_writeback_cache_ctrl_unit.f -----
rtl/salwcc_pkg.sv
rtl/salwcc_req_if.sv
rtl/salwcc_rsp_if.sv
rtl/salwcc_set_store.sv
rtl/salwcc_lookup.sv
rtl/set_assoc_lru_writeback_cache_ctrl_unit.sv
tb/set_assoc_lru_writeback_cache_ctrl_unit_tb.sv
